// ===== hw/rtl/mau_pkg.sv =====
`timescale 1ns / 1ps
package mau_pkg;
    localparam int OPERAND_BITS_DEF = 64;

    typedef enum logic [2:0] {
        OP_REDUCE = 3'd0,
        OP_ADD    = 3'd1,
        OP_SUB    = 3'd2,
        OP_MUL    = 3'd3,
        OP_EXP    = 3'd4
    } t_opcode;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RED_A,
        ST_RED_B,
        ST_SUB_FIX,
        ST_MUL,
        ST_MUL_RED,
        ST_EXP_SCAN,
        ST_EXP_SQ,
        ST_EXP_SQ_RED,
        ST_EXP_ML,
        ST_EXP_ML_RED,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_unit_ctl;
endpackage

// ===== hw/rtl/mau_if.sv =====
`timescale 1ns / 1ps
interface mau_in_if #(parameter int W = 64);
    logic         valid;
    logic         ready;
    logic [2:0]   opcode;
    logic [W-1:0] operand_a;
    logic [W-1:0] operand_b;
    logic [W-1:0] modulus;
    modport source (output valid, opcode, operand_a, operand_b, modulus, input ready);
    modport sink   (input valid, opcode, operand_a, operand_b, modulus, output ready);
endinterface

interface mau_out_if #(parameter int W = 64);
    logic         valid;
    logic         ready;
    logic [W-1:0] residue;
    logic         bad_modulus;
    modport source (output valid, residue, bad_modulus, input ready);
    modport sink   (input valid, residue, bad_modulus, output ready);
endinterface

// ===== hw/rtl/modular_arithmetic_unit.sv =====
`timescale 1ns / 1ps
// flow: one item at a time, the next beat is accepted no earlier than the cycle after the result beat;
// the multiplier and the remainder unit are both bit-serial
// reset: synchronous active low, clears the sequencer and returns to idle
module modular_arithmetic_unit import mau_pkg::*; #(
    parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    mau_in_if.sink    i_in,
    mau_out_if.source o_out
);
    localparam int W  = OPERAND_BITS;
    localparam int BW = $clog2(W);

    t_state          r_state, n_state;
    logic [2:0]      r_op;
    logic [W-1:0]    r_a, r_b, r_m, r_acc, r_base, r_am, r_res;
    logic            r_bad;
    logic [BW-1:0]   r_bit;
    logic            r_seen;

    logic            w_mul_start, w_red_start;
    logic [W-1:0]    w_mx, w_my;
    logic [2*W-1:0]  w_rval, w_prod;
    logic [W-1:0]    w_rem;
    t_unit_ctl       w_mctl, w_rctl;

    logic            r_go_m, r_go_r, n_go_m, n_go_r;
    logic [2*W-1:0]  r_redsrc;
    logic [W:0]      w_sum;

    mau_mul #(.W(W)) u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_mul_start),
        .i_x(w_mx), .i_y(w_my), .o_ctl(w_mctl), .o_prod(w_prod)
    );
    mau_red #(.W(W)) u_red (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_red_start),
        .i_val(w_rval), .i_mod(r_m), .o_ctl(w_rctl), .o_rem(w_rem)
    );

    logic w_acc;
    assign w_acc = i_in.valid && i_in.ready;
    assign w_sum = {1'b0, i_in.operand_a} + {1'b0, i_in.operand_b};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    if (i_in.modulus == '0) n_state = ST_OUT;
                    else if (i_in.opcode == OP_MUL) n_state = ST_MUL;
                    else n_state = ST_RED_A;
                end
            end
            ST_RED_A: begin
                if (w_rctl.done) begin
                    if (r_op == OP_SUB) n_state = ST_RED_B;
                    else if (r_op == OP_EXP) n_state = ST_EXP_SCAN;
                    else n_state = ST_OUT;
                end
            end
            ST_RED_B:      if (w_rctl.done) n_state = ST_SUB_FIX;
            ST_SUB_FIX:    n_state = ST_OUT;
            ST_MUL:        if (w_mctl.done) n_state = ST_MUL_RED;
            ST_MUL_RED:    if (w_rctl.done) n_state = ST_OUT;
            ST_EXP_SCAN: begin
                if (r_seen || r_b[r_bit]) n_state = ST_EXP_SQ;
                else if (r_bit == '0) n_state = ST_OUT;
            end
            ST_EXP_SQ:     if (w_mctl.done) n_state = ST_EXP_SQ_RED;
            ST_EXP_SQ_RED: begin
                if (w_rctl.done) begin
                    if (r_b[r_bit]) n_state = ST_EXP_ML;
                    else if (r_bit == '0) n_state = ST_OUT;
                    else n_state = ST_EXP_SQ;
                end
            end
            ST_EXP_ML:     if (w_mctl.done) n_state = ST_EXP_ML_RED;
            ST_EXP_ML_RED: begin
                if (w_rctl.done) begin
                    if (r_bit == '0) n_state = ST_OUT;
                    else n_state = ST_EXP_SQ;
                end
            end
            ST_OUT:        if (o_out.ready) n_state = ST_IDLE;
            default:       n_state = ST_IDLE;
        endcase
    end

    // unit starts, registered so that they are asserted in the first cycle of the state that uses the unit
    always_comb begin
        n_go_m = (r_state == ST_IDLE && w_acc && i_in.modulus != '0 && i_in.opcode == OP_MUL)
              || (r_state == ST_EXP_SCAN && r_b[r_bit])
              || (r_state == ST_EXP_SQ_RED && w_rctl.done && (r_b[r_bit] || r_bit != '0))
              || (r_state == ST_EXP_ML_RED && w_rctl.done && r_bit != '0);
        n_go_r = (r_state == ST_IDLE && w_acc && i_in.modulus != '0 && i_in.opcode != OP_MUL)
              || (r_state == ST_RED_A && w_rctl.done && r_op == OP_SUB)
              || ((r_state == ST_MUL || r_state == ST_EXP_SQ || r_state == ST_EXP_ML)
                  && w_mctl.done);
    end

    // unit control
    always_comb begin
        w_mul_start = r_go_m;
        w_red_start = r_go_r;
        w_mx   = r_acc;
        w_my   = r_acc;
        w_rval = w_prod;
        case (r_state)
            ST_RED_A: w_rval = r_redsrc;
            ST_RED_B: w_rval = {{W{1'b0}}, r_b};
            ST_MUL: begin
                w_mx = r_a;
                w_my = r_b;
            end
            ST_EXP_ML: w_my = r_base;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_go_m  <= 1'b0;
            r_go_r  <= 1'b0;
            r_seen  <= 1'b0;
            r_bad   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_go_m  <= n_go_m;
            r_go_r  <= n_go_r;
            case (r_state)
                ST_IDLE: begin
                    if (w_acc) begin
                        r_op  <= i_in.opcode;
                        r_a   <= i_in.operand_a;
                        r_b   <= i_in.operand_b;
                        r_m   <= i_in.modulus;
                        r_bad <= (i_in.modulus == '0);
                        r_res <= '0;
                        r_seen <= 1'b0;
                        r_bit <= BW'(W - 1);
                        r_redsrc <= (i_in.opcode == OP_ADD) ? {{(W-1){1'b0}}, w_sum}
                                                            : {{W{1'b0}}, i_in.operand_a};
                    end
                end
                ST_RED_A: begin
                    if (w_rctl.done) begin
                        r_am   <= w_rem;
                        r_base <= w_rem;
                        // 1 mod m
                        r_acc  <= (r_m == W'(1)) ? '0 : W'(1);
                        r_res  <= (r_op != OP_EXP) ? w_rem : ((r_m == W'(1)) ? '0 : W'(1));
                    end
                end
                ST_RED_B: begin
                    if (w_rctl.done) r_res <= w_rem;
                end
                ST_SUB_FIX: begin
                    r_res <= (r_am >= r_res) ? W'(r_am - r_res) : W'(r_m - (r_res - r_am));
                end
                ST_MUL_RED: if (w_rctl.done) r_res <= w_rem;
                ST_EXP_SCAN: begin
                    if (r_b[r_bit]) begin
                        r_seen <= 1'b1;
                    end else if (r_bit != '0) begin
                        r_bit <= r_bit - 1'b1;
                    end
                end
                ST_EXP_SQ_RED: begin
                    if (w_rctl.done) begin
                        r_acc <= w_rem;
                        r_res <= w_rem;
                        if (!r_b[r_bit] && r_bit != '0) r_bit <= r_bit - 1'b1;
                    end
                end
                ST_EXP_ML_RED: begin
                    if (w_rctl.done) begin
                        r_acc <= w_rem;
                        r_res <= w_rem;
                        if (r_bit != '0) r_bit <= r_bit - 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign i_in.ready        = (r_state == ST_IDLE);
    assign o_out.valid       = (r_state == ST_OUT);
    assign o_out.residue     = r_bad ? '0 : r_res;
    assign o_out.bad_modulus = r_bad;

    a_ready_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("ready while result pending");
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && r_bad) |-> (r_m == '0))
        else $error("error flag with nonzero modulus");
    a_res_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !r_bad) |-> (r_res < r_m))
        else $error("residue out of range");
endmodule

// ===== hw/rtl/mau_mul.sv =====
`timescale 1ns / 1ps
// shift-add multiplier, one operand bit per cycle
module mau_mul import mau_pkg::*; #(
    parameter int W = OPERAND_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [W-1:0]   i_x,
    input  logic [W-1:0]   i_y,
    output t_unit_ctl      o_ctl,
    output logic [2*W-1:0] o_prod
);
    localparam int CW = $clog2(W + 1);
    logic [2*W-1:0] r_acc, n_acc;
    logic [2*W-1:0] r_x;
    logic [W-1:0]   r_y;
    logic [CW-1:0]  r_cnt;
    logic           r_busy, r_done;

    always_comb begin
        n_acc = r_acc;
        if (r_y[0]) begin
            n_acc = r_acc + r_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
                r_acc  <= '0;
                r_x    <= {{W{1'b0}}, i_x};
                r_y    <= i_y;
            end else if (r_busy) begin
                r_acc <= n_acc;
                r_x   <= r_x << 1;
                r_y   <= r_y >> 1;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_ctl  = '{start: i_start, busy: r_busy, done: r_done};
    assign o_prod = r_acc;
endmodule

// ===== hw/rtl/mau_red.sv =====
`timescale 1ns / 1ps
// restoring remainder of a double-width value, one dividend bit per cycle
module mau_red import mau_pkg::*; #(
    parameter int W = OPERAND_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [2*W-1:0] i_val,
    input  logic [W-1:0]   i_mod,
    output t_unit_ctl      o_ctl,
    output logic [W-1:0]   o_rem
);
    localparam int CW = $clog2(2 * W + 1);
    logic [W-1:0]   r_rem;
    logic [2*W-1:0] r_val;
    logic [W-1:0]   r_mod;
    logic [CW-1:0]  r_cnt;
    logic           r_busy, r_done;
    logic [W:0]     w_sh;
    logic [W-1:0]   n_rem;

    always_comb begin
        w_sh  = {r_rem, r_val[2*W-1]};
        n_rem = w_sh[W-1:0];
        if (w_sh >= {1'b0, r_mod}) begin
            n_rem = W'(w_sh - {1'b0, r_mod});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(2 * W);
                r_rem  <= '0;
                r_val  <= i_val;
                r_mod  <= i_mod;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_val <= r_val << 1;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_ctl = '{start: i_start, busy: r_busy, done: r_done};
    assign o_rem = r_rem;

    a_rem_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < r_mod))
        else $error("remainder not reduced");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("done without busy");
endmodule
